// File: sv/assert_macros.svh
// Assertion macros shared by the prime sieve counter RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked assertion that is disabled while reset is held.
`define PSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define PSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/psc_pkg.sv
// Package of the prime sieve counter: field widths and sequencer states.
// No dependencies; used by the channel interfaces and the top level.
package psc_pkg;

    localparam int LIMIT_W = 17;
    localparam int COUNT_W = 13;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SQR,
        S_CHECK,
        S_STRIKE,
        S_FIND,
        S_FWAIT,
        S_COUNT,
        S_DONE
    } t_state;

endpackage

// File: sv/psc_limit_if.sv
// Request channel of the prime sieve counter: valid/ready plus the limit.
// Depends on psc_pkg for the field width.
interface psc_limit_if;
    logic                          valid;
    logic                          ready;
    logic [psc_pkg::LIMIT_W-1:0]   limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

// File: sv/psc_count_if.sv
// Result channel of the prime sieve counter: valid/ready plus the count.
// Depends on psc_pkg for the field width.
interface psc_count_if;
    logic                          valid;
    logic                          ready;
    logic [psc_pkg::COUNT_W-1:0]   prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

// File: sv/prime_sieve_counter.sv
// Prime sieve counter: a request with limit n clears the bit map for 0 to n-1, then for each
// sieving value k with k*k <= n strikes the multiples of k below n and finds the next candidate;
// at last it counts the candidates from two up to n-1 and offers that count on o_res.
// The bit map takes one write and one read a cycle. Only one request is in work;
// i_req.ready is high only while the sequencer is idle and reset is released.
// Reset clears the sequencer and the output valid; the map is rewritten per request.
module prime_sieve_counter #(
    parameter int MAX_LIMIT = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psc_limit_if.sink   i_req,
    psc_count_if.source o_res
);
    import psc_pkg::*;

    // Map address width, width of a limit value, and width of the walk index, which
    // may step past n by up to one sieving value before the loop sees it.
    localparam int AW = $clog2(MAX_LIMIT);
    localparam int NW = $clog2(MAX_LIMIT + 1);
    localparam int IW = NW + 1;
    localparam int XW = (NW > LIMIT_W) ? NW : LIMIT_W;
    localparam int PW = 2 * AW;

    t_state             r_state, n_state;
    logic [NW-1:0]      r_n;
    logic [AW-1:0]      r_k;
    logic [IW-1:0]      r_idx;
    logic [PW-1:0]      r_prod;
    logic [COUNT_W-1:0] r_count;
    logic               r_rd_pend;
    logic               r_rdata;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    // The bit map: one bit per number, 1 while the number is still a prime candidate.
    logic r_map [MAX_LIMIT];

    logic          w_accept;
    logic          w_in_range;
    logic          w_sq_ok;
    logic          w_load_out;
    logic [NW-1:0] w_n;
    logic [XW-1:0] w_lim_x;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic          w_wd;
    logic          w_re;
    logic [AW-1:0] w_ra;

    // The incoming limit saturates to the size of the map.
    assign w_lim_x = XW'(i_req.limit);
    assign w_n     = (w_lim_x > XW'(MAX_LIMIT)) ? NW'(MAX_LIMIT) : NW'(w_lim_x);

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_in_range = r_idx < IW'(r_n);
    // The square of the sieving value is registered in S_SQR and compared here.
    assign w_sq_ok    = r_prod <= PW'(r_n);
    // A finished count moves to the output register once the previous result is gone.
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_CLEAR;
            S_CLEAR:  if (!w_in_range) n_state = S_SQR;
            S_SQR:    n_state = S_CHECK;
            S_CHECK:  n_state = w_sq_ok ? S_STRIKE : S_COUNT;
            S_STRIKE: if (!w_in_range) n_state = S_FIND;
            S_FIND:   n_state = w_in_range ? S_FWAIT : S_COUNT;
            S_FWAIT:  n_state = r_rdata ? S_SQR : S_FIND;
            S_COUNT:  if (!w_in_range && !r_rd_pend) n_state = S_DONE;
            S_DONE:   if (w_load_out) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Map port control and the request handshake.
    always_comb begin
        i_req.ready = 1'b0;
        w_we = 1'b0;
        w_wa = r_idx[AW-1:0];
        w_wd = 1'b0;
        w_re = 1'b0;
        w_ra = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                // No item is taken while reset is held.
                i_req.ready = i_rst_n;
            end
            S_CLEAR: begin
                w_we = w_in_range;
                w_wd = 1'b1;
            end
            S_STRIKE: begin
                // Multiples of k are struck; when the walk passes n, k itself is kept.
                w_we = 1'b1;
                if (!w_in_range) begin
                    w_wa = r_k;
                    w_wd = 1'b1;
                end
            end
            S_FIND, S_COUNT: begin
                w_re = w_in_range;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rdata <= r_map[w_ra];
        end
    end

    // Sequencer state and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_COUNT) && w_in_range;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Limit, walk index, sieving value, its square, running count and output count.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_n     <= w_n;
                    r_idx   <= '0;
                    r_count <= '0;
                end
            end
            S_CLEAR: begin
                if (w_in_range) begin
                    r_idx <= r_idx + IW'(1);
                end else begin
                    r_k <= AW'(2);
                end
            end
            S_SQR: begin
                r_prod <= PW'(r_k) * PW'(r_k);
            end
            S_CHECK: begin
                r_idx <= w_sq_ok ? IW'(r_k) : IW'(2);
            end
            S_STRIKE: begin
                if (w_in_range) begin
                    r_idx <= r_idx + IW'(r_k);
                end else begin
                    r_idx <= IW'(r_k) + IW'(1);
                end
            end
            S_FIND: begin
                // No candidate left below n: the sieve ends and counting starts at two.
                if (!w_in_range) begin
                    r_idx <= IW'(2);
                end
            end
            S_FWAIT: begin
                if (r_rdata) begin
                    r_k <= r_idx[AW-1:0];
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            S_COUNT: begin
                if (w_in_range) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (r_rd_pend && r_rdata) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    r_out_count <= r_count;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.prime_count = r_out_count;

`include "assert_macros.svh"

    `PSC_ASSERT(a_accept_starts_clear, i_clk, i_rst_n, w_accept |=> (r_state == S_CLEAR), "accepted request did not start the clearing pass")
    `PSC_ASSERT(a_write_below_limit, i_clk, i_rst_n, w_we |-> (NW'(w_wa) < r_n), "map write at or above the limit")
    `PSC_ASSERT(a_sieve_value_range, i_clk, i_rst_n, (r_state == S_STRIKE) |-> ((r_k >= AW'(2)) && (NW'(r_k) < r_n)), "sieving value out of range")
    `PSC_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_DONE), "result raised outside the done state")
    `PSC_ASSERT(a_count_pending_only, i_clk, i_rst_n, r_rd_pend |-> (r_state == S_COUNT), "count read pending outside the counting walk")

endmodule
